// File: hdl/flr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// flr_pkg: shared types and constants for the forest link/reroot block
// Holds the node table geometry, the beat structs of both channels and the
// sequencer state encoding.
// ---------------------------------------------------------------------------
package flr_pkg;

  // Table geometry
  localparam int NODE_COUNT = 1024;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int STEP_W     = $clog2(NODE_COUNT + 1);
  localparam int NODE_W     = 10;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STEP_W-1:0] step_t;

  // Request codes
  typedef enum logic [0:0] {
    OP_LINK = 1'b0,
    OP_FIND = 1'b1
  } op_e;

  // One parent table entry
  typedef struct packed {
    logic  has_parent;
    node_t parent;
  } link_t;

  // Channel beats
  typedef struct packed {
    op_e   op;
    node_t node_a;
    node_t node_b;
  } in_beat_t;

  typedef struct packed {
    logic  linked;
    node_t root_node;
  } out_beat_t;

  // Table port request
  typedef struct packed {
    logic  we;
    addr_t waddr;
    link_t wdata;
    addr_t raddr;
  } ram_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RR_WALK,
    ST_FB_REQ,
    ST_FB_WALK,
    ST_FIND_WALK,
    ST_RESP
  } state_e;

  function automatic logic in_range(node_t node);
    return 32'(node) < NODE_COUNT;
  endfunction

  function automatic addr_t to_addr(node_t node);
    return addr_t'(node);
  endfunction

endpackage
`default_nettype wire

// File: hdl/forest_link_with_reroot.sv
`default_nettype none
// ---------------------------------------------------------------------------
// forest_link_with_reroot: dynamic forest with evert-and-link and find-root
// Parent link table walked one link per cycle by a small sequencer.
// ---------------------------------------------------------------------------
// After reset the block sweeps all NODE_COUNT (1024) entries of the parent
// table, one entry a cycle, with in_ready_o low. A find walks from node_a
// to its root; a link first reverses the path from node_a to its old root
// and then walks from node_b to its root. Links are followed one per cycle:
// the single read port of the table delivers one entry per clock. One item
// is worked on at a time; a finished result sits in the output register
// and the next item can be accepted while it waits.
// ---------------------------------------------------------------------------
module forest_link_with_reroot (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire flr_pkg::in_beat_t    in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output flr_pkg::out_beat_t        out_data_o
);

  flr_pkg::state_e    state_q, state_d;
  flr_pkg::addr_t     clr_q, clr_d;
  flr_pkg::node_t     a_q, a_d, b_q, b_d, cur_q, cur_d, root_q, root_d;
  flr_pkg::link_t     prev_q, prev_d;
  flr_pkg::step_t     steps_q, steps_d;
  logic               linked_q, linked_d;
  flr_pkg::out_beat_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  flr_pkg::ram_req_t  ram_req;
  flr_pkg::link_t     rd;
  logic               in_beat;
  logic               walk_end;
  logic               bound_hit;

  flr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd)
  );

  assign in_beat   = in_valid_i && in_ready_o;
  assign bound_hit = (steps_q == flr_pkg::STEP_W'(flr_pkg::NODE_COUNT));
  // A walk stops at a root, at a bad index or at the step bound
  assign walk_end  = bound_hit || !rd.has_parent || !flr_pkg::in_range(rd.parent);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flr_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    root_q   <= root_d;
    linked_q <= linked_d;
    out_q    <= out_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    root_d      = root_q;
    linked_d    = linked_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_req     = '{we: 1'b0, waddr: flr_pkg::to_addr(cur_q), wdata: prev_q,
                    raddr: flr_pkg::to_addr(cur_q)};

    case (state_q)
      // Sweep the table to "no parent"
      flr_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
        ram_req.wdata = '0;
        clr_d         = clr_q + 1'b1;
        if (clr_q == flr_pkg::ADDR_W'(flr_pkg::NODE_COUNT - 1)) begin
          state_d = flr_pkg::ST_IDLE;
        end
      end

      // Take a request and start the first read at node_a
      flr_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ram_req.raddr = flr_pkg::to_addr(in_data_i.node_a);
        if (in_beat) begin
          a_d      = in_data_i.node_a;
          b_d      = in_data_i.node_b;
          cur_d    = in_data_i.node_a;
          prev_d   = '0;
          steps_d  = '0;
          linked_d = 1'b0;
          root_d   = in_data_i.node_a;
          state_d  = flr_pkg::ST_RESP;
          if (in_data_i.op == flr_pkg::OP_FIND) begin
            if (flr_pkg::in_range(in_data_i.node_a)) begin
              state_d = flr_pkg::ST_FIND_WALK;
            end
          end else if (flr_pkg::in_range(in_data_i.node_a) &&
                       flr_pkg::in_range(in_data_i.node_b)) begin
            state_d = flr_pkg::ST_RR_WALK;
          end
        end
      end

      // Re-root: reverse one link per cycle
      flr_pkg::ST_RR_WALK: begin
        if (bound_hit) begin
          state_d = flr_pkg::ST_FB_REQ;
        end else begin
          ram_req.we = 1'b1;
          if (!rd.has_parent || !flr_pkg::in_range(rd.parent)) begin
            state_d = flr_pkg::ST_FB_REQ;
          end else begin
            prev_d        = '{has_parent: 1'b1, parent: cur_q};
            cur_d         = rd.parent;
            steps_d       = steps_q + 1'b1;
            ram_req.raddr = flr_pkg::to_addr(rd.parent);
          end
        end
      end

      // Start the walk from node_b once the last reversal has landed
      flr_pkg::ST_FB_REQ: begin
        ram_req.raddr = flr_pkg::to_addr(b_q);
        cur_d         = b_q;
        steps_d       = '0;
        state_d       = flr_pkg::ST_FB_WALK;
      end

      // Walk node_b up to its root, then link if the trees differ
      flr_pkg::ST_FB_WALK: begin
        if (walk_end) begin
          state_d = flr_pkg::ST_RESP;
          if (cur_q != a_q) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = flr_pkg::to_addr(a_q);
            ram_req.wdata = '{has_parent: 1'b1, parent: b_q};
            linked_d      = 1'b1;
            root_d        = cur_q;
          end else begin
            root_d = a_q;
          end
        end else begin
          cur_d         = rd.parent;
          steps_d       = steps_q + 1'b1;
          ram_req.raddr = flr_pkg::to_addr(rd.parent);
        end
      end

      // Walk node_a up to its root
      flr_pkg::ST_FIND_WALK: begin
        if (walk_end) begin
          root_d  = cur_q;
          state_d = flr_pkg::ST_RESP;
        end else begin
          cur_d         = rd.parent;
          steps_d       = steps_q + 1'b1;
          ram_req.raddr = flr_pkg::to_addr(rd.parent);
        end
      end

      // Load the output register once it is free
      flr_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = '{linked: linked_q, root_node: root_q};
          out_valid_d = 1'b1;
          state_d     = flr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = flr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: hdl/flr_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// flr_ram: parent link table
// One write port and one read port; read data is registered and returns
// the old contents on a same-address write.
// ---------------------------------------------------------------------------
module flr_ram (
  input  wire                      clk_i,
  input  wire flr_pkg::ram_req_t   req_i,
  output flr_pkg::link_t           rdata_o
);

  flr_pkg::link_t mem [flr_pkg::NODE_COUNT];
  flr_pkg::link_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/flr_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// flr_checker: port-level checks for the forest link/reroot block
// Watches the handshake and the busy behavior around requests and reset.
// ---------------------------------------------------------------------------
module flr_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_o,
  input wire                      out_valid_o,
  input wire                      out_ready_i,
  input wire flr_pkg::out_beat_t  out_data_o
);

  // A result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One request at a time: busy right after a request beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // Table sweep keeps the input closed right after reset
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("request port open during table sweep");

endmodule

bind forest_link_with_reroot flr_checker u_flr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// File: bench/tb_forest_link_with_reroot.sv
// ---------------------------------------------------------------------------
// tb_forest_link_with_reroot: self-checking bench for the forest link block
// A directed table of requests is run first, and then a few hundred random
// requests. The random part mostly links nodes from a small sliding window
// and grows long chains, so trees get deep and "already connected" links are
// common. A shadow parent table predicts every result not fixed in the plan.
// Both channels stall in random bursts, except near the end of the run.
// ---------------------------------------------------------------------------
module tb_forest_link_with_reroot;

  localparam int RAND_ITEMS   = 268;
  localparam int QUIET_TAIL   = 40;         // no stalls over the last beats
  localparam int DRAIN_CYCLES = 2100;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOT_SPAN     = 48;

  typedef struct {
    flr_pkg::in_beat_t  req;
    bit                 typed;
    flr_pkg::out_beat_t want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  flr_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  flr_pkg::out_beat_t out_data_o;

  // shadow of the parent table and the results still owed by the block
  flr_pkg::link_t      shadow_links [flr_pkg::NODE_COUNT];
  flr_pkg::out_beat_t  owed_results [$];
  plan_row_t           plan [$];
  int                  mismatch_cnt;
  int                  cycle_cnt;
  bit                  stalls_on;

  flr_pkg::in_beat_t   rnd_req;
  flr_pkg::node_t      chain_tail;
  int                  hot_base;
  int                  pick;
  flr_pkg::out_beat_t  head;

  forest_link_with_reroot dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --- shadow forest ------------------------------------------------------

  function automatic bit node_ok(flr_pkg::node_t n);
    return int'(n) < flr_pkg::NODE_COUNT;
  endfunction

  function automatic flr_pkg::node_t root_of(flr_pkg::node_t n);
    flr_pkg::node_t cur;
    int             steps;
    cur = n;
    for (steps = 0; steps < flr_pkg::NODE_COUNT; steps++) begin
      if (!shadow_links[cur].has_parent || !node_ok(shadow_links[cur].parent))
        break;
      cur = shadow_links[cur].parent;
    end
    return cur;
  endfunction

  // reverse the links from n up to its root so that n becomes the root
  function automatic void evert_at(flr_pkg::node_t n);
    flr_pkg::node_t cur;
    flr_pkg::link_t old;
    flr_pkg::link_t carry;
    int             steps;
    cur   = n;
    carry = '0;
    for (steps = 0; steps < flr_pkg::NODE_COUNT; steps++) begin
      old               = shadow_links[cur];
      shadow_links[cur] = carry;
      if (!old.has_parent || !node_ok(old.parent))
        break;
      carry.has_parent = 1'b1;
      carry.parent     = cur;
      cur              = old.parent;
    end
  endfunction

  function automatic flr_pkg::out_beat_t forest_apply(flr_pkg::in_beat_t req);
    flr_pkg::out_beat_t res;
    flr_pkg::node_t     b_root;
    res.linked    = 1'b0;
    res.root_node = req.node_a;
    if (req.op == flr_pkg::OP_FIND) begin
      if (node_ok(req.node_a))
        res.root_node = root_of(req.node_a);
    end else if (node_ok(req.node_a) && node_ok(req.node_b)) begin
      evert_at(req.node_a);
      b_root = root_of(req.node_b);
      if (b_root != req.node_a) begin
        shadow_links[req.node_a].has_parent = 1'b1;
        shadow_links[req.node_a].parent     = req.node_b;
        res.linked    = 1'b1;
        res.root_node = b_root;
      end
    end
    return res;
  endfunction

  // --- request side -------------------------------------------------------

  // hold the beat until accepted, then log what the block owes for it
  task automatic push_request(input flr_pkg::in_beat_t req, input bit typed,
                              input flr_pkg::out_beat_t want);
    flr_pkg::out_beat_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = forest_apply(req);
    owed_results.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    if (stalls_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain_owed();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic plan_row(input flr_pkg::op_e op, input int a, input int b,
                          input bit typed = 1'b0, input bit lk = 1'b0,
                          input int root = 0);
    plan_row_t r;
    r.req.op          = op;
    r.req.node_a      = flr_pkg::node_t'(a);
    r.req.node_b      = flr_pkg::node_t'(b);
    r.typed           = typed;
    r.want.linked     = lk;
    r.want.root_node  = flr_pkg::node_t'(root);
    plan.push_back(r);
  endtask

  function automatic flr_pkg::node_t hot_node();
    return flr_pkg::node_t'(hot_base + $urandom_range(0, HOT_SPAN - 1));
  endfunction

  // --- main sequence ------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    mismatch_cnt = 0;
    stalls_on    = 1'b1;
    for (int n = 0; n < flr_pkg::NODE_COUNT; n++) shadow_links[n] = '0;

    // directed table: extremes, both ops, self link, connected, chains
    plan_row(flr_pkg::OP_FIND, 0, 0, 1'b1, 1'b0, 0);
    plan_row(flr_pkg::OP_FIND, 1023, 0, 1'b1, 1'b0, 1023);
    plan_row(flr_pkg::OP_LINK, 5, 5, 1'b1, 1'b0, 5);          // self link
    plan_row(flr_pkg::OP_LINK, 0, 1023, 1'b1, 1'b1, 1023);
    plan_row(flr_pkg::OP_FIND, 0, 1023, 1'b1, 1'b0, 1023);
    plan_row(flr_pkg::OP_LINK, 1023, 0, 1'b1, 1'b0, 1023);    // already connected
    plan_row(flr_pkg::OP_LINK, 0, 1023);                      // connected, flips edge
    plan_row(flr_pkg::OP_FIND, 1023, 0);
    plan_row(flr_pkg::OP_LINK, 682, 341, 1'b1, 1'b1, 341);    // alternating bits
    plan_row(flr_pkg::OP_LINK, 341, 0);
    plan_row(flr_pkg::OP_FIND, 682, 1023);
    plan_row(flr_pkg::OP_LINK, 1023, 682);
    plan_row(flr_pkg::OP_FIND, 0, 0);
    plan_row(flr_pkg::OP_LINK, 10, 11, 1'b1, 1'b1, 11);
    plan_row(flr_pkg::OP_LINK, 11, 12);
    plan_row(flr_pkg::OP_LINK, 12, 13);
    plan_row(flr_pkg::OP_FIND, 10, 0);
    plan_row(flr_pkg::OP_LINK, 10, 13);                       // reverses the chain
    plan_row(flr_pkg::OP_FIND, 13, 0);
    plan_row(flr_pkg::OP_LINK, 13, 341);                      // merges two trees
    plan_row(flr_pkg::OP_FIND, 1023, 0);
    plan_row(flr_pkg::OP_LINK, 1022, 1, 1'b1, 1'b1, 1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      push_request(plan[k].req, plan[k].typed, plan[k].want);
      if (k == plan.size() - 1) drain_owed();
      else sender_gap();
    end

    // random part: window links, chain growth, finds and wide links
    hot_base   = $urandom_range(0, flr_pkg::NODE_COUNT - HOT_SPAN);
    chain_tail = hot_node();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 60 == 59) hot_base = $urandom_range(0, flr_pkg::NODE_COUNT - HOT_SPAN);
      if (i >= RAND_ITEMS - QUIET_TAIL) stalls_on = 1'b0;
      pick = $urandom_range(0, 99);
      rnd_req.op     = flr_pkg::OP_LINK;
      rnd_req.node_a = hot_node();
      rnd_req.node_b = hot_node();
      if (pick < 20) begin
        rnd_req.node_a = chain_tail;
        rnd_req.node_b = flr_pkg::node_t'($urandom_range(0, flr_pkg::NODE_COUNT - 1));
        chain_tail     = rnd_req.node_b;
      end else if (pick < 45) begin
        rnd_req.op = flr_pkg::OP_FIND;
        if (pick < 30) rnd_req.node_a = chain_tail;
        else if (pick < 36)
          rnd_req.node_a = flr_pkg::node_t'($urandom_range(0, flr_pkg::NODE_COUNT - 1));
      end else if (pick < 55) begin
        rnd_req.node_a = flr_pkg::node_t'($urandom_range(0, flr_pkg::NODE_COUNT - 1));
        rnd_req.node_b = flr_pkg::node_t'($urandom_range(0, flr_pkg::NODE_COUNT - 1));
      end
      push_request(rnd_req, 1'b0, '0);
      if (i == RAND_ITEMS / 2) drain_owed();
      else if (i == RAND_ITEMS - 1) in_valid_i <= 1'b0;
      else sender_gap();
    end

    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("tb_forest_link_with_reroot: PASS");
    else
      $display("tb_forest_link_with_reroot: FAIL");
    $finish;
  end

  // --- result side --------------------------------------------------------

  // ready in random bursts, held high once stalls are switched off
  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      repeat ($urandom_range(1, 24)) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
      if (stalls_on) begin
        repeat ($urandom_range(1, 13)) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  end

  // compare each accepted result beat with the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        $error("result beat with none owed: linked=%0d root_node=%0d",
               out_data_o.linked, out_data_o.root_node);
        mismatch_cnt++;
      end else begin
        head = owed_results.pop_front();
        if (out_data_o.linked !== head.linked) begin
          $error("linked: expected %0d, actual %0d", head.linked, out_data_o.linked);
          mismatch_cnt++;
        end
        if (out_data_o.root_node !== head.root_node) begin
          $error("root_node: expected %0d, actual %0d",
                 head.root_node, out_data_o.root_node);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_forest_link_with_reroot: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/flr_pkg.sv
hdl/flr_ram.sv
hdl/forest_link_with_reroot.sv
hdl/flr_checker.sv
bench/tb_forest_link_with_reroot.sv
